[sv/pfr_pkg.sv]
package pfr_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int SIZE_W  = 10;
  localparam int ACC_W   = 16;
  localparam int ENTRY_W = 6;
  localparam int LEVEL_W = 7;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic front_start;
    logic i_next;
    logic j_clear;
    logic j_step;
    logic decide;
    logic level_inc;
    logic out_start;
    logic out_load;
    logic clear_set;
  } pfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fire_last;
    logic i_end;
    logic fresh_i;
    logic j_end;
    logic all_ranked;
    logic last_k;
    logic out_taken;
  } pfr_sts_t;

endpackage

[sv/pfr_if.sv]
interface pfr_in_if;
  import pfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] classifier_count;
  logic [ACC_W-1:0]  accuracy_fixed;
  logic              last_item;

  modport source (output valid, output classifier_count, output accuracy_fixed,
                  output last_item, input ready);
  modport sink   (input valid, input classifier_count, input accuracy_fixed,
                  input last_item, output ready);
endinterface

interface pfr_out_if;
  import pfr_pkg::*;

  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] entry_index;
  logic [LEVEL_W-1:0] front_level;
  logic               last_result;

  modport source (output valid, output entry_index, output front_level,
                  output last_result, input ready);
  modport sink   (input valid, input entry_index, input front_level,
                  input last_result, output ready);
endinterface

[sv/pfr_datapath.sv]
module pfr_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  pfr_pkg::pfr_cmd_t cmd,
  output pfr_pkg::pfr_sts_t sts,
  pfr_in_if.sink            in_ch,
  pfr_out_if.source         out_ch
);
  import pfr_pkg::*;

  // candidate and level memories
  logic [SIZE_W-1:0]  size_mem [MAX_ENTRIES];
  logic [ACC_W-1:0]   acc_mem  [MAX_ENTRIES];
  logic [LEVEL_W-1:0] lvl_mem  [MAX_ENTRIES];

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       i_r;
  logic [CNT_W-1:0]       j_r;
  logic [LEVEL_W-1:0]     level_r;
  logic [MAX_ENTRIES-1:0] unranked_r;
  logic [MAX_ENTRIES-1:0] fresh_r;
  logic                   beaten_r;
  logic                   jv_r;
  logic [SIZE_W-1:0]      si_r, sj_r;
  logic [ACC_W-1:0]       ai_r, aj_r;
  logic [LEVEL_W-1:0]     lvl_rd_r;
  logic                   out_valid_r;
  logic [ENTRY_W-1:0]     out_index_r;
  logic [LEVEL_W-1:0]     out_level_r;
  logic                   out_last_r;

  logic [IDX_W-1:0] i_idx, j_idx, w_idx;
  logic             fire, full, j_beats_i, taken;

  assign i_idx = i_r[IDX_W-1:0];
  assign j_idx = j_r[IDX_W-1:0];
  assign w_idx = count_r[IDX_W-1:0];
  assign full  = (count_r == CNT_W'(MAX_ENTRIES));
  assign fire  = cmd.accept && in_ch.valid;
  assign taken = out_valid_r && out_ch.ready;

  assign j_beats_i = ((sj_r <= si_r) && (aj_r > ai_r)) || ((sj_r < si_r) && (aj_r >= ai_r));

  assign in_ch.ready        = cmd.accept;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_index = out_index_r;
  assign out_ch.front_level = out_level_r;
  assign out_ch.last_result = out_last_r;

  assign sts.fire_last  = fire && in_ch.last_item;
  assign sts.i_end      = (i_r == count_r);
  assign sts.fresh_i    = fresh_r[i_idx];
  assign sts.j_end      = (j_r == count_r);
  assign sts.all_ranked = (unranked_r == '0);
  assign sts.last_k     = ((i_r + CNT_W'(1)) == count_r);
  assign sts.out_taken  = taken;

  // memory write and read ports
  always_ff @(posedge clk) begin
    if (fire && !full) begin
      size_mem[w_idx] <= in_ch.classifier_count;
      acc_mem[w_idx]  <= in_ch.accuracy_fixed;
    end
    if (cmd.decide && !beaten_r) begin
      lvl_mem[i_idx] <= level_r;
    end
    si_r     <= size_mem[i_idx];
    ai_r     <= acc_mem[i_idx];
    sj_r     <= size_mem[j_idx];
    aj_r     <= acc_mem[j_idx];
    lvl_rd_r <= lvl_mem[i_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      level_r     <= LEVEL_W'(1);
      unranked_r  <= '0;
      fresh_r     <= '0;
      beaten_r    <= 1'b0;
      jv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire && !full) begin
        count_r           <= count_r + CNT_W'(1);
        unranked_r[w_idx] <= 1'b1;
      end
      if (cmd.front_start) begin
        fresh_r <= unranked_r;
        i_r     <= '0;
      end
      if (cmd.out_start) i_r <= '0;
      if (cmd.i_next)    i_r <= i_r + CNT_W'(1);
      if (cmd.level_inc) level_r <= level_r + LEVEL_W'(1);
      if (cmd.j_clear) begin
        j_r      <= '0;
        beaten_r <= 1'b0;
      end else if (jv_r && j_beats_i) begin
        beaten_r <= 1'b1;
      end
      jv_r <= cmd.j_step && fresh_r[j_idx];
      if (cmd.j_step) j_r <= j_r + CNT_W'(1);
      if (cmd.decide && !beaten_r) unranked_r[i_idx] <= 1'b0;
      if (cmd.out_load)  out_valid_r <= 1'b1;
      else if (taken)    out_valid_r <= 1'b0;
      if (cmd.clear_set) begin
        count_r    <= '0;
        i_r        <= '0;
        level_r    <= LEVEL_W'(1);
        unranked_r <= '0;
      end
    end
  end

  // result word, payload only
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index_r <= ENTRY_W'(i_r);
      out_level_r <= lvl_rd_r;
      out_last_r  <= sts.last_k;
    end
  end

endmodule

[sv/pfr_ctrl.sv]
module pfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  pfr_pkg::pfr_sts_t sts,
  output pfr_pkg::pfr_cmd_t cmd
);
  import pfr_pkg::*;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_FRONT  = 3'd1;
  localparam logic [2:0] S_ISCAN  = 3'd2;
  localparam logic [2:0] S_JRUN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_OUTRD  = 3'd5;
  localparam logic [2:0] S_OUTLD  = 3'd6;
  localparam logic [2:0] S_OUTWT  = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        cmd.accept = 1'b1;
        if (sts.fire_last) state_nxt = S_FRONT;
      end
      S_FRONT: begin
        if (sts.all_ranked) begin
          cmd.out_start = 1'b1;
          state_nxt     = S_OUTRD;
        end else begin
          cmd.front_start = 1'b1;
          state_nxt       = S_ISCAN;
        end
      end
      S_ISCAN: begin
        if (sts.i_end) begin
          cmd.level_inc = 1'b1;
          state_nxt     = S_FRONT;
        end else if (sts.fresh_i) begin
          cmd.j_clear = 1'b1;
          state_nxt   = S_JRUN;
        end else begin
          cmd.i_next = 1'b1;
        end
      end
      S_JRUN: begin
        if (!sts.j_end) cmd.j_step = 1'b1;
        else            state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.i_next = 1'b1;
        state_nxt  = S_ISCAN;
      end
      S_OUTRD: state_nxt = S_OUTLD;
      S_OUTLD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_OUTWT;
      end
      S_OUTWT: begin
        if (sts.out_taken) begin
          if (sts.last_k) begin
            cmd.clear_set = 1'b1;
            state_nxt     = S_LOAD;
          end else begin
            cmd.i_next = 1'b1;
            state_nxt  = S_OUTRD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else        state_r <= state_nxt;
  end

endmodule

[sv/pareto_front_ranker.sv]
// Two-objective Pareto ranker. Candidates (size, lower is better; accuracy,
// higher is better) are loaded one word per cycle, up to MAX_ENTRIES; words
// beyond that are dropped, but a last_item mark on any word starts ranking.
// Ranking runs one dominance compare per cycle through the candidate memory's
// second read port: each front steps through the stored entries, and each
// entry still unranked at the front's start is compared against every entry
// in that same unranked set. Then one result word per entry leaves in load
// order, each held until the output takes it, and the set is cleared. No
// input is taken from the last_item word until the final result has been
// delivered.
module pareto_front_ranker (
  input  logic      clk,
  input  logic      rst_n,
  pfr_in_if.sink    in_ch,
  pfr_out_if.source out_ch
);
  import pfr_pkg::*;

  // command and status between sequencer and datapath
  pfr_cmd_t cmd;
  pfr_sts_t sts;

  // sequencer: load, front scans, result drain
  pfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // stores, counters, dominance compare and result register
  pfr_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // loading and result drain never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result word is pending");

  // after the final result the block is back to loading
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_result) |=> in_ch.ready)
    else $error("not ready for a new set after the final result");

  // every delivered entry has been placed in some front
  a_level_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.front_level != '0))
    else $error("result word with unranked level");

  // a last_item word leads straight into ranking
  a_rank_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_item) |=> !in_ch.ready)
    else $error("still loading after the last item");

endmodule
